// ===== rtl/o2s_pkg.sv =====
// ============================================================================
// OKLab to sRGB package
// Shared widths, fixed-point coefficients and width helpers for the
// OKLab to gamma-encoded sRGB pipeline.
// ============================================================================
`default_nettype none

package o2s_pkg;

    // Default parameter values
    localparam int O2S_IN_FRAC_BITS  = 14;
    localparam int O2S_LUT_ADDR_BITS = 12;
    localparam int O2S_OUT_BITS      = 12;

    // Fixed field and arithmetic widths
    localparam int IN_W      = 15;             // input field width
    localparam int COEF_W    = 28;             // signed Q24 coefficient
    localparam int COEF_FRAC = 24;
    localparam int PROD_W    = IN_W + COEF_W;  // chroma times coefficient
    localparam int SUM_W     = 42;             // l', m', s' before rounding
    localparam int CUBE_FRAC = 16;             // Q16 for l', m', s' and cubes
    localparam int LIN_FRAC  = 40;             // linear RGB is Q40

    typedef logic signed [COEF_W-1:0] t_coef;

    // Decimal constant (scaled by 1e10) to Q24, round to nearest
    function automatic longint q24(input longint n);
        return (n * (longint'(1) << COEF_FRAC) + 64'sd5000000000) / 64'sd10000000000;
    endfunction

    // Width of rounded l', m', s' (Q16, signed)
    function automatic int lms_w(input int frac);
        return SUM_W - (frac + COEF_FRAC - CUBE_FRAC) + 1;
    endfunction

    // Width of rounded square (Q16, signed, non-negative)
    function automatic int sq_w(input int frac);
        return 2 * lms_w(frac) - CUBE_FRAC;
    endfunction

    // Width of rounded cube (Q16, signed)
    function automatic int cube_w(input int frac);
        return sq_w(frac) + lms_w(frac) - CUBE_FRAC + 1;
    endfunction

    // Width of linear RGB (Q40, signed), headroom for clamp compare
    function automatic int lin_w(input int frac);
        return cube_w(frac) + COEF_W + 3;
    endfunction

    // Inverse OKLab matrix, chroma columns (lightness column is 1.0)
    localparam t_coef K_L_A = t_coef'(q24(64'sd3963377774));
    localparam t_coef K_L_B = t_coef'(q24(64'sd2158037573));
    localparam t_coef K_M_A = t_coef'(-q24(64'sd1055613458));
    localparam t_coef K_M_B = t_coef'(-q24(64'sd638541728));
    localparam t_coef K_S_A = t_coef'(-q24(64'sd894841775));
    localparam t_coef K_S_B = t_coef'(-q24(64'sd12914855480));

    // LMS to linear sRGB matrix, row-major (red, green, blue) x (l, m, s)
    localparam t_coef K_RGB [9] = '{
        t_coef'(q24(64'sd40767416621)),
        t_coef'(-q24(64'sd33077115913)),
        t_coef'(q24(64'sd2309699292)),
        t_coef'(-q24(64'sd12684380046)),
        t_coef'(q24(64'sd26097574011)),
        t_coef'(-q24(64'sd3413193965)),
        t_coef'(-q24(64'sd41960863)),
        t_coef'(-q24(64'sd7034186147)),
        t_coef'(q24(64'sd17076147010))
    };

endpackage

`default_nettype wire

// ===== rtl/o2s_in_if.sv =====
// ============================================================================
// OKLab pixel stream interface
// Valid/ready channel carrying one OKLab colour per transaction.
// ============================================================================
`default_nettype none

interface o2s_in_if import o2s_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [IN_W-1:0]        lightness;
    logic signed [IN_W-1:0] chroma_a;
    logic signed [IN_W-1:0] chroma_b;

    modport source (
        output valid, lightness, chroma_a, chroma_b,
        input  ready
    );

    modport sink (
        input  valid, lightness, chroma_a, chroma_b,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/o2s_out_if.sv =====
// ============================================================================
// sRGB pixel stream interface
// Valid/ready channel carrying one gamma-encoded sRGB pixel per transaction.
// ============================================================================
`default_nettype none

interface o2s_out_if import o2s_pkg::*; #(
    parameter int OUT_BITS = O2S_OUT_BITS
) ();

    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;

    modport source (
        output valid, red, green, blue,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/o2s_lms.sv =====
// ============================================================================
// OKLab to l', m', s'
// Three-stage section: chroma products, matrix sums, rounding to Q16.
// ============================================================================
`default_nettype none

module o2s_lms import o2s_pkg::*; #(
    parameter int IN_FRAC_BITS = O2S_IN_FRAC_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_vld,
    output logic                                     o_rdy,
    input  wire logic [IN_W-1:0]                     i_lightness,
    input  wire logic signed [IN_W-1:0]              i_chroma_a,
    input  wire logic signed [IN_W-1:0]              i_chroma_b,
    output logic                                     o_vld,
    input  wire logic                                i_rdy,
    output logic signed [lms_w(IN_FRAC_BITS)-1:0]    o_lms [3]
);

    localparam int SH    = IN_FRAC_BITS + COEF_FRAC - CUBE_FRAC;
    localparam int LMS_W = lms_w(IN_FRAC_BITS);
    localparam int LQ_W  = IN_W + COEF_FRAC;
    localparam int NS    = 3;
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(longint'(1) << (SH - 1));

    logic [NS-1:0]              r_vld;
    logic [NS-1:0]              vld_up;
    logic [NS-1:0]              adv;

    logic [LQ_W-1:0]            r_lq;
    logic signed [PROD_W-1:0]   r_prod [6];
    logic signed [PROD_W-1:0]   n_prod [6];
    logic signed [SUM_W-1:0]    r_sum  [3];
    logic signed [SUM_W-1:0]    n_sum  [3];
    logic signed [SUM_W-1:0]    n_rnd  [3];
    logic signed [LMS_W-1:0]    r_lms  [3];

    // Stage advance: a stage loads when empty or when the next one loads
    always_comb begin
        adv[NS-1] = ~r_vld[NS-1] | i_rdy;
        for (int s = NS - 2; s >= 0; s--) begin
            adv[s] = ~r_vld[s] | adv[s+1];
        end
    end

    assign vld_up = {r_vld[NS-2:0], i_vld};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= vld_up[s];
                end
            end
        end
    end

    // Stage 1: chroma times matrix coefficients
    always_comb begin
        n_prod[0] = PROD_W'(i_chroma_a) * PROD_W'(K_L_A);
        n_prod[1] = PROD_W'(i_chroma_b) * PROD_W'(K_L_B);
        n_prod[2] = PROD_W'(i_chroma_a) * PROD_W'(K_M_A);
        n_prod[3] = PROD_W'(i_chroma_b) * PROD_W'(K_M_B);
        n_prod[4] = PROD_W'(i_chroma_a) * PROD_W'(K_S_A);
        n_prod[5] = PROD_W'(i_chroma_b) * PROD_W'(K_S_B);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_lq   <= {i_lightness, {COEF_FRAC{1'b0}}};
            r_prod <= n_prod;
        end
    end

    // Stage 2: lightness plus both chroma terms
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = SUM_W'($signed({1'b0, r_lq})) + SUM_W'(r_prod[2*k])
                     + SUM_W'(r_prod[2*k+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_sum <= n_sum;
        end
    end

    // Stage 3: round to Q16, half away from zero
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_rnd[k] = r_sum[k] + RND_HALF - SUM_W'(r_sum[k][SUM_W-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            for (int k = 0; k < 3; k++) begin
                r_lms[k] <= LMS_W'(n_rnd[k] >>> SH);
            end
        end
    end

    assign o_rdy = adv[0];
    assign o_vld = r_vld[NS-1];
    assign o_lms = r_lms;

endmodule

`default_nettype wire

// ===== rtl/o2s_cube.sv =====
// ============================================================================
// LMS cube
// Four-stage section cubing l', m', s' in Q16 with rounding after each
// multiplication; three lanes side by side.
// ============================================================================
`default_nettype none

module o2s_cube import o2s_pkg::*; #(
    parameter int IN_FRAC_BITS = O2S_IN_FRAC_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_vld,
    output logic                                      o_rdy,
    input  wire logic signed [lms_w(IN_FRAC_BITS)-1:0] i_lms [3],
    output logic                                      o_vld,
    input  wire logic                                 i_rdy,
    output logic signed [cube_w(IN_FRAC_BITS)-1:0]    o_cube [3]
);

    localparam int LMS_W = lms_w(IN_FRAC_BITS);
    localparam int SQ_W  = sq_w(IN_FRAC_BITS);
    localparam int CU_W  = cube_w(IN_FRAC_BITS);
    localparam int X2_W  = 2 * LMS_W;
    localparam int SX_W  = SQ_W + LMS_W;
    localparam int NS    = 4;
    localparam longint RND16 = longint'(1) << (CUBE_FRAC - 1);

    logic [NS-1:0]            r_vld;
    logic [NS-1:0]            vld_up;
    logic [NS-1:0]            adv;

    logic signed [LMS_W-1:0]  r_x_a  [3];
    logic signed [LMS_W-1:0]  r_x_b  [3];
    logic signed [X2_W-1:0]   r_x2   [3];
    logic signed [X2_W-1:0]   n_x2r  [3];
    logic signed [SQ_W-1:0]   r_sq   [3];
    logic signed [SX_W-1:0]   r_sx   [3];
    logic signed [SX_W-1:0]   n_sxr  [3];
    logic signed [CU_W-1:0]   r_cu   [3];

    // Stage advance
    always_comb begin
        adv[NS-1] = ~r_vld[NS-1] | i_rdy;
        for (int s = NS - 2; s >= 0; s--) begin
            adv[s] = ~r_vld[s] | adv[s+1];
        end
    end

    assign vld_up = {r_vld[NS-2:0], i_vld};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= vld_up[s];
                end
            end
        end
    end

    // Rounding adds for the square and the cube
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_x2r[k] = r_x2[k] + X2_W'(RND16) - X2_W'(r_x2[k][X2_W-1]);
            n_sxr[k] = r_sx[k] + SX_W'(RND16) - SX_W'(r_sx[k][SX_W-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            // Stage 4: square
            if (adv[0]) begin
                r_x_a[k] <= i_lms[k];
                r_x2[k]  <= X2_W'(i_lms[k]) * X2_W'(i_lms[k]);
            end
            // Stage 5: square back to Q16
            if (adv[1]) begin
                r_x_b[k] <= r_x_a[k];
                r_sq[k]  <= SQ_W'(n_x2r[k] >>> CUBE_FRAC);
            end
            // Stage 6: square times value
            if (adv[2]) begin
                r_sx[k] <= SX_W'(r_sq[k]) * SX_W'(r_x_b[k]);
            end
            // Stage 7: cube back to Q16
            if (adv[3]) begin
                r_cu[k] <= CU_W'(n_sxr[k] >>> CUBE_FRAC);
            end
        end
    end

    assign o_rdy  = adv[0];
    assign o_vld  = r_vld[NS-1];
    assign o_cube = r_cu;

endmodule

`default_nettype wire

// ===== rtl/o2s_rgb.sv =====
// ============================================================================
// LMS to linear sRGB
// Two-stage section: nine coefficient products, then per-channel sums
// giving linear red, green and blue in Q40.
// ============================================================================
`default_nettype none

module o2s_rgb import o2s_pkg::*; #(
    parameter int IN_FRAC_BITS = O2S_IN_FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_vld,
    output logic                                       o_rdy,
    input  wire logic signed [cube_w(IN_FRAC_BITS)-1:0] i_cube [3],
    output logic                                       o_vld,
    input  wire logic                                  i_rdy,
    output logic signed [lin_w(IN_FRAC_BITS)-1:0]      o_lin [3]
);

    localparam int CU_W  = cube_w(IN_FRAC_BITS);
    localparam int LIN_W = lin_w(IN_FRAC_BITS);
    localparam int MP_W  = COEF_W + CU_W;
    localparam int NS    = 2;

    logic [NS-1:0]            r_vld;
    logic [NS-1:0]            vld_up;
    logic [NS-1:0]            adv;

    logic signed [MP_W-1:0]   r_prod [9];
    logic signed [LIN_W-1:0]  r_lin  [3];

    // Stage advance
    always_comb begin
        adv[NS-1] = ~r_vld[NS-1] | i_rdy;
        for (int s = NS - 2; s >= 0; s--) begin
            adv[s] = ~r_vld[s] | adv[s+1];
        end
    end

    assign vld_up = {r_vld[NS-2:0], i_vld};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= vld_up[s];
                end
            end
        end
    end

    // Stage 8: products; stage 9: row sums
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            for (int c = 0; c < 3; c++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[3*c+j] <= MP_W'(K_RGB[3*c+j]) * MP_W'(i_cube[j]);
                end
            end
        end
        if (adv[1]) begin
            for (int c = 0; c < 3; c++) begin
                r_lin[c] <= LIN_W'(r_prod[3*c]) + LIN_W'(r_prod[3*c+1])
                          + LIN_W'(r_prod[3*c+2]);
            end
        end
    end

    assign o_rdy = adv[0];
    assign o_vld = r_vld[NS-1];
    assign o_lin = r_lin;

endmodule

`default_nettype wire

// ===== rtl/o2s_gamma.sv =====
// ============================================================================
// sRGB transfer curve
// Three-stage section: clamp to [0,1], quantize to a table address and read
// the transfer-curve ROM (one copy per channel, registered read).
// ============================================================================
`default_nettype none

module o2s_gamma import o2s_pkg::*; #(
    parameter int IN_FRAC_BITS        = O2S_IN_FRAC_BITS,
    parameter int GAMMA_LUT_ADDR_BITS = O2S_LUT_ADDR_BITS,
    parameter int OUT_BITS            = O2S_OUT_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_vld,
    output logic                                      o_rdy,
    input  wire logic signed [lin_w(IN_FRAC_BITS)-1:0] i_lin [3],
    output logic                                      o_vld,
    input  wire logic                                 i_rdy,
    output logic [OUT_BITS-1:0]                       o_red,
    output logic [OUT_BITS-1:0]                       o_green,
    output logic [OUT_BITS-1:0]                       o_blue
);

    localparam int LIN_W     = lin_w(IN_FRAC_BITS);
    localparam int AW        = GAMMA_LUT_ADDR_BITS;
    localparam int V_W       = LIN_FRAC + 1;
    localparam int SC_W      = V_W + AW + 1;
    localparam int LUT_DEPTH = 1 << AW;
    localparam int NS        = 3;

    localparam longint unsigned LUT_MAX  = longint'(LUT_DEPTH - 1);
    localparam longint unsigned OUT_MAX  = (longint'(1) << OUT_BITS) - 1;
    localparam longint unsigned Q30_ONE  = longint'(1) << 30;
    localparam longint unsigned LIN_DEN  = 100 * LUT_MAX;
    localparam longint unsigned GAM_DEN  = 1000 * Q30_ONE;
    localparam longint unsigned GAM_OFS  = 55 * OUT_MAX * Q30_ONE;
    localparam longint unsigned GAM_HALF = 500 * Q30_ONE;

    localparam logic signed [LIN_W-1:0] LIN_ONE  = LIN_W'(longint'(1) << LIN_FRAC);
    localparam logic [SC_W-1:0]         ADR_HALF = SC_W'(longint'(1) << (LIN_FRAC - 1));

    // Transfer curve entry, evaluated at elaboration only
    function automatic logic [OUT_BITS-1:0] curve_entry(input longint unsigned idx);
        longint unsigned xq;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned z2;
        longint unsigned z4;
        longint unsigned z8;
        longint unsigned z12;
        longint unsigned y;
        longint unsigned num;
        longint unsigned code;
        if (idx * 64'd10000000 < 64'd31308 * LUT_MAX) begin
            // linear toe
            code = (64'd1292 * idx * OUT_MAX + 64'd50 * LUT_MAX) / LIN_DEN;
        end else begin
            // x^(1/2.4) as (x^(1/12))^5, root found by bisection in Q30
            xq = ((idx << 30) + (LUT_MAX >> 1)) / LUT_MAX;
            lo = 0;
            hi = Q30_ONE;
            for (int k = 0; k < 32; k++) begin
                if (lo < hi) begin
                    mid = lo + ((hi - lo + 1) >> 1);
                    z2  = (mid * mid) >> 30;
                    z4  = (z2 * z2) >> 30;
                    z8  = (z4 * z4) >> 30;
                    z12 = (z8 * z4) >> 30;
                    if (z12 <= xq) begin
                        lo = mid;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
            z2  = (lo * lo) >> 30;
            z4  = (z2 * z2) >> 30;
            y   = (z4 * lo) >> 30;
            num = 64'd1055 * y * OUT_MAX;
            if (num < GAM_OFS) begin
                code = 0;
            end else begin
                code = (num - GAM_OFS + GAM_HALF) / GAM_DEN;
            end
        end
        if (code > OUT_MAX) begin
            code = OUT_MAX;
        end
        return OUT_BITS'(code);
    endfunction

    logic [NS-1:0]          r_vld;
    logic [NS-1:0]          vld_up;
    logic [NS-1:0]          adv;

    logic [V_W-1:0]         r_v    [3];
    logic [V_W-1:0]         n_v    [3];
    logic [SC_W-1:0]        n_sc   [3];
    logic [AW-1:0]          r_addr [3];
    logic [OUT_BITS-1:0]    r_code [3];
    logic [OUT_BITS-1:0]    rom    [3][LUT_DEPTH];

    // Curve ROM contents, one copy per channel
    for (genvar e = 0; e < LUT_DEPTH; e++) begin : g_ent
        localparam logic [OUT_BITS-1:0] ENTRY = curve_entry(longint'(e));
        assign rom[0][e] = ENTRY;
        assign rom[1][e] = ENTRY;
        assign rom[2][e] = ENTRY;
    end

    // Stage advance
    always_comb begin
        adv[NS-1] = ~r_vld[NS-1] | i_rdy;
        for (int s = NS - 2; s >= 0; s--) begin
            adv[s] = ~r_vld[s] | adv[s+1];
        end
    end

    assign vld_up = {r_vld[NS-2:0], i_vld};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= vld_up[s];
                end
            end
        end
    end

    // Clamp to [0, 1.0] and scale to table address: (v*(depth-1) + half) >> 40
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (i_lin[c][LIN_W-1]) begin
                n_v[c] = '0;
            end else if (i_lin[c] > LIN_ONE) begin
                n_v[c] = V_W'(LIN_ONE);
            end else begin
                n_v[c] = i_lin[c][V_W-1:0];
            end
            n_sc[c] = ({1'b0, r_v[c], {AW{1'b0}}}) - SC_W'(r_v[c]) + ADR_HALF;
        end
    end

    // Stage 10: clamp; stage 11: address; stage 12: ROM read
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (adv[0]) begin
                r_v[c] <= n_v[c];
            end
            if (adv[1]) begin
                r_addr[c] <= n_sc[c][LIN_FRAC +: AW];
            end
            if (adv[2]) begin
                r_code[c] <= rom[c][r_addr[c]];
            end
        end
    end

    assign o_rdy   = adv[0];
    assign o_vld   = r_vld[NS-1];
    assign o_red   = r_code[0];
    assign o_green = r_code[1];
    assign o_blue  = r_code[2];

endmodule

`default_nettype wire

// ===== rtl/oklab_to_srgb_converter.sv =====
// ============================================================================
// OKLab to sRGB converter
// Converts one fixed-point OKLab colour per transaction into gamma-encoded
// sRGB: inverse OKLab matrix, cube, LMS-to-linear matrix, clamp, curve ROM.
// ============================================================================
//
//  Port     Dir  Handshake      Payload
//  -------  ---  -------------  ------------------------------------------
//  i_pix    in   valid / ready  lightness u15, chroma_a s15, chroma_b s15
//  o_pix    out  valid / ready  red, green, blue (OUT_BITS each, unsigned)
//
//  One transaction per clock sustained while the output is ready; twelve
//  register stages (products, sums, rounding, cube, RGB matrix, clamp,
//  address, registered curve ROM read).
//  Each stage holds its own valid bit; a stalled output only holds the
//  stages behind it that are full, so empty stages keep filling.
//  Synchronous active-low reset clears the valid bits; the ROM is constant
//  and needs no fill after reset.
// ============================================================================
`default_nettype none

module oklab_to_srgb_converter import o2s_pkg::*; #(
    parameter int IN_FRAC_BITS        = O2S_IN_FRAC_BITS,
    parameter int GAMMA_LUT_ADDR_BITS = O2S_LUT_ADDR_BITS,
    parameter int OUT_BITS            = O2S_OUT_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    o2s_in_if.sink     i_pix,
    o2s_out_if.source  o_pix
);

    localparam int LMS_W = lms_w(IN_FRAC_BITS);
    localparam int CU_W  = cube_w(IN_FRAC_BITS);
    localparam int LIN_W = lin_w(IN_FRAC_BITS);

    logic                     lms_vld;
    logic                     lms_rdy;
    logic signed [LMS_W-1:0]  lms_data [3];
    logic                     cube_vld;
    logic                     cube_rdy;
    logic signed [CU_W-1:0]   cube_data [3];
    logic                     lin_vld;
    logic                     lin_rdy;
    logic signed [LIN_W-1:0]  lin_data [3];

    // l', m', s'
    o2s_lms #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_lms (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (i_pix.valid),
        .o_rdy       (i_pix.ready),
        .i_lightness (i_pix.lightness),
        .i_chroma_a  (i_pix.chroma_a),
        .i_chroma_b  (i_pix.chroma_b),
        .o_vld       (lms_vld),
        .i_rdy       (lms_rdy),
        .o_lms       (lms_data)
    );

    // cubes
    o2s_cube #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_cube (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (lms_vld),
        .o_rdy   (lms_rdy),
        .i_lms   (lms_data),
        .o_vld   (cube_vld),
        .i_rdy   (cube_rdy),
        .o_cube  (cube_data)
    );

    // linear RGB
    o2s_rgb #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_rgb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (cube_vld),
        .o_rdy   (cube_rdy),
        .i_cube  (cube_data),
        .o_vld   (lin_vld),
        .i_rdy   (lin_rdy),
        .o_lin   (lin_data)
    );

    // transfer curve and output register
    o2s_gamma #(
        .IN_FRAC_BITS        (IN_FRAC_BITS),
        .GAMMA_LUT_ADDR_BITS (GAMMA_LUT_ADDR_BITS),
        .OUT_BITS            (OUT_BITS)
    ) u_gamma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (lin_vld),
        .o_rdy   (lin_rdy),
        .i_lin   (lin_data),
        .o_vld   (o_pix.valid),
        .i_rdy   (o_pix.ready),
        .o_red   (o_pix.red),
        .o_green (o_pix.green),
        .o_blue  (o_pix.blue)
    );

endmodule

`default_nettype wire

// ===== sim/oklab_to_srgb_checker.sv =====
// ============================================================================
// OKLab to sRGB checker
// Watches both pixel channels of the converter, computes the expected sRGB
// pixel for every accepted OKLab colour and compares results in order.
// ============================================================================
`default_nettype none

module oklab_to_srgb_checker import o2s_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    o2s_in_if         pix_in,
    o2s_out_if        pix_out,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int              OBITS     = O2S_OUT_BITS;
    localparam int              CURVE_LEN = 1 << O2S_LUT_ADDR_BITS;
    localparam longint unsigned CURVE_TOP = CURVE_LEN - 1;
    localparam longint unsigned CODE_MAX  = (64'd1 << OBITS) - 1;
    localparam longint unsigned Q30_UNIT  = 64'd1 << 30;
    localparam longint unsigned LIN_UNIT  = 64'd1 << 40;
    localparam int              LMS_SHIFT = O2S_IN_FRAC_BITS + 24 - 16;

    typedef struct packed {
        logic [OBITS-1:0] red;
        logic [OBITS-1:0] green;
        logic [OBITS-1:0] blue;
    } t_srgb_pixel;

    // Decimal constant given as value * 1e10, to Q24 rounded to nearest
    function automatic longint fix24(input longint scaled_e10);
        return (scaled_e10 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000;
    endfunction

    // Inverse OKLab matrix, chroma columns (magnitudes, signs applied below)
    localparam longint LA = fix24(64'sd3963377774);
    localparam longint LB = fix24(64'sd2158037573);
    localparam longint MA = fix24(64'sd1055613458);
    localparam longint MB = fix24(64'sd638541728);
    localparam longint SA = fix24(64'sd894841775);
    localparam longint SB = fix24(64'sd12914855480);

    // LMS to linear sRGB matrix (magnitudes)
    localparam longint RL = fix24(64'sd40767416621);
    localparam longint RM = fix24(64'sd33077115913);
    localparam longint RS = fix24(64'sd2309699292);
    localparam longint GL = fix24(64'sd12684380046);
    localparam longint GM = fix24(64'sd26097574011);
    localparam longint GS = fix24(64'sd3413193965);
    localparam longint BL = fix24(64'sd41960863);
    localparam longint BM = fix24(64'sd7034186147);
    localparam longint BS = fix24(64'sd17076147010);

    logic [OBITS-1:0] gamma_table [CURVE_LEN];
    t_srgb_pixel      expected_pixels [$];
    t_srgb_pixel      want;
    int               errors_seen = 0;

    // Shift right with rounding to nearest, ties away from zero
    function automatic longint round_shift(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic longint cube_q16(input longint x);
        longint sq;
        sq = round_shift(x * x, 16);
        return round_shift(sq * x, 16);
    endfunction

    function automatic longint unsigned q30_mul(input longint unsigned x,
                                                input longint unsigned y);
        return (x * y) >> 30;
    endfunction

    function automatic longint unsigned twelfth_power(input longint unsigned z);
        longint unsigned z2, z4, z8;
        z2 = q30_mul(z, z);
        z4 = q30_mul(z2, z2);
        z8 = q30_mul(z4, z4);
        return q30_mul(z8, z4);
    endfunction

    // sRGB transfer curve code for table address idx
    function automatic longint unsigned curve_code(input longint unsigned idx);
        longint unsigned xq, lo, hi, mid, z2, z4, y, num, code;
        if (idx * 64'd10000000 < 64'd31308 * CURVE_TOP)
            return (64'd1292 * idx * CODE_MAX + 64'd50 * CURVE_TOP) / (64'd100 * CURVE_TOP);
        xq = ((idx << 30) + CURVE_TOP / 2) / CURVE_TOP;
        lo = 0;
        hi = Q30_UNIT;
        // largest z with z^12 <= x, i.e. z = x^(1/12)
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (twelfth_power(mid) <= xq)
                lo = mid;
            else
                hi = mid - 1;
        end
        z2 = q30_mul(lo, lo);
        z4 = q30_mul(z2, z2);
        y  = q30_mul(z4, lo);
        num = 64'd1055 * y * CODE_MAX;
        if (num < 64'd55 * CODE_MAX * Q30_UNIT)
            return 0;
        num = num - 64'd55 * CODE_MAX * Q30_UNIT + 64'd500 * Q30_UNIT;
        code = num / (64'd1000 * Q30_UNIT);
        return (code > CODE_MAX) ? CODE_MAX : code;
    endfunction

    // Clamp a Q40 linear channel to [0,1] and look up its gamma code
    function automatic logic [OBITS-1:0] gamma_encode(input longint lin);
        longint unsigned v;
        if (lin < 0)
            v = 0;
        else if (lin > longint'(LIN_UNIT))
            v = LIN_UNIT;
        else
            v = longint'(lin);
        return gamma_table[(v * CURVE_TOP + (64'd1 << 39)) >> 40];
    endfunction

    function automatic t_srgb_pixel srgb_from_oklab(
        input logic [IN_W-1:0]        lightness,
        input logic signed [IN_W-1:0] chroma_a,
        input logic signed [IN_W-1:0] chroma_b
    );
        longint      lq, ca, cb, lc, mc, sc, r, g, b;
        t_srgb_pixel px;
        lq = longint'(lightness) * 64'sd16777216;
        ca = longint'(chroma_a);
        cb = longint'(chroma_b);
        lc = cube_q16(round_shift(lq + LA * ca + LB * cb, LMS_SHIFT));
        mc = cube_q16(round_shift(lq - MA * ca - MB * cb, LMS_SHIFT));
        sc = cube_q16(round_shift(lq - SA * ca - SB * cb, LMS_SHIFT));
        r  =  RL * lc - RM * mc + RS * sc;
        g  = -GL * lc + GM * mc - GS * sc;
        b  = -BL * lc - BM * mc + BS * sc;
        px.red   = gamma_encode(r);
        px.green = gamma_encode(g);
        px.blue  = gamma_encode(b);
        return px;
    endfunction

    // Build the curve table once, before any pixel arrives
    initial begin
        for (int i = 0; i < CURVE_LEN; i++)
            gamma_table[i] = OBITS'(curve_code(longint'(i)));
    end

    // Queue expectations on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_pixels.delete();
        end else begin
            if (pix_in.valid && pix_in.ready)
                expected_pixels.insert(expected_pixels.size(),
                                       srgb_from_oklab(pix_in.lightness,
                                                       pix_in.chroma_a,
                                                       pix_in.chroma_b));
            if (pix_out.valid && pix_out.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel out with no colour pending: %0d %0d %0d",
                           pix_out.red, pix_out.green, pix_out.blue);
                    errors_seen++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (pix_out.red !== want.red) begin
                        $error("red: expected %0d, actual %0d", want.red, pix_out.red);
                        errors_seen++;
                    end
                    if (pix_out.green !== want.green) begin
                        $error("green: expected %0d, actual %0d", want.green, pix_out.green);
                        errors_seen++;
                    end
                    if (pix_out.blue !== want.blue) begin
                        $error("blue: expected %0d, actual %0d", want.blue, pix_out.blue);
                        errors_seen++;
                    end
                end
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= errors_seen;
    end

endmodule

`default_nettype wire

// ===== sim/oklab_to_srgb_converter_test.sv =====
// ============================================================================
// OKLab to sRGB converter test
// Feeds corner-case and random OKLab colours through the converter with
// bursty input and a stalling output; the checker beside it compares every
// pixel against its own computation of the conversion.
// ============================================================================
`default_nettype none

module oklab_to_srgb_converter_test import o2s_pkg::*; ();

    localparam int RANDOM_COLOURS = 1000;
    localparam int DRAIN_CYCLES   = 24;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   colours_sent = 0;
    int   directed_count = 0;
    int   burst_left = 0;
    int   drain_pauses = 0;
    int   long_holds = 0;

    o2s_in_if  pix_in ();
    o2s_out_if pix_out ();

    oklab_to_srgb_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    oklab_to_srgb_checker pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .pix_in       (pix_in),
        .pix_out      (pix_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one colour; in bursty mode a new gap opens when the current burst is used up
    task automatic offer_colour(input int l, input int a, input int b, input bit bursty);
        if (bursty && burst_left == 0) begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        pix_in.valid     <= 1'b1;
        pix_in.lightness <= l[IN_W-1:0];
        pix_in.chroma_a  <= a[IN_W-1:0];
        pix_in.chroma_b  <= b[IN_W-1:0];
        do @(posedge i_clk); while (!pix_in.ready);
        if (burst_left > 0)
            burst_left--;
        colours_sent++;
    endtask

    // Stop sending until every pixel in flight has come out
    task automatic drain_pipeline();
        pix_in.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        burst_left = 0;
        drain_pauses++;
    endtask

    // Random colour: mostly realistic chroma, some full range, some raw bits, some corners
    task automatic pick_colour(output int l, output int a, output int b);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            l = $urandom_range(0, 16384);
            a = int'($urandom_range(0, 13107)) - 6554;
            b = int'($urandom_range(0, 13107)) - 6554;
        end else if (kind == 7) begin
            l = $urandom_range(0, 16384);
            a = int'($urandom_range(0, 32767)) - 16384;
            b = int'($urandom_range(0, 32767)) - 16384;
        end else if (kind == 8) begin
            l = $urandom_range(0, 32767);
            a = $urandom_range(0, 32767);
            b = $urandom_range(0, 32767);
        end else begin
            case ($urandom_range(0, 2))
                0: l = 0;
                1: l = 16384;
                default: l = 32767;
            endcase
            case ($urandom_range(0, 3))
                0: a = -16384;
                1: a = 16383;
                2: a = -1;
                default: a = 0;
            endcase
            case ($urandom_range(0, 3))
                0: b = -16384;
                1: b = 16383;
                2: b = 1;
                default: b = 0;
            endcase
        end
    endtask

    // Output ready: rotating stall modes plus periodic long hold-offs
    initial begin
        int cycle_no;
        int hold_left;
        cycle_no  = 0;
        hold_left = 0;
        pix_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cycle_no++;
            if (hold_left > 0) begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end else if (i_rst_n && cycle_no % 700 == 350) begin
                hold_left = 60;
                long_holds++;
                pix_out.ready <= 1'b0;
            end else begin
                case ((cycle_no / 128) % 4)
                    0: pix_out.ready <= 1'b1;
                    1: pix_out.ready <= ($urandom_range(0, 3) != 0);
                    2: pix_out.ready <= 1'($urandom_range(0, 1));
                    default: pix_out.ready <= (cycle_no % 5 != 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int l, a, b;
        i_rst_n          <= 1'b0;
        pix_in.valid     <= 1'b0;
        pix_in.lightness <= '0;
        pix_in.chroma_a  <= '0;
        pix_in.chroma_b  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corners: black, white, over-range L, extreme chroma, dark grays
        // in the linear part of the curve, primaries, and out-of-gamut colours
        offer_colour(0,     0,      0,      1'b1);
        offer_colour(16384, 0,      0,      1'b1);
        offer_colour(32767, 0,      0,      1'b1);
        offer_colour(8192,  0,      0,      1'b1);
        offer_colour(1,     0,      0,      1'b1);
        offer_colour(16,    0,      0,      1'b1);
        offer_colour(1024,  0,      0,      1'b1);
        offer_colour(10289, 3685,   2061,   1'b1);
        offer_colour(14195, -3832,  2941,   1'b1);
        offer_colour(7406,  -532,   -5105,  1'b1);
        offer_colour(16384, 16383,  16383,  1'b1);
        offer_colour(16384, -16384, -16384, 1'b1);
        offer_colour(16384, 16383,  -16384, 1'b1);
        offer_colour(16384, -16384, 16383,  1'b1);
        offer_colour(0,     16383,  16383,  1'b1);
        offer_colour(0,     -16384, -16384, 1'b1);
        offer_colour(32767, 16383,  16383,  1'b1);
        offer_colour(32767, -16384, -16384, 1'b1);
        offer_colour(32767, 16383,  -16384, 1'b1);
        offer_colour(16384, -1,     -1,     1'b1);
        offer_colour(16384, 1,      1,      1'b1);
        offer_colour(12000, 6000,   -6000,  1'b1);
        directed_count = colours_sent;
        drain_pipeline();

        // Random colours; one stretch runs back to back, one drain mid-way
        for (int n = 0; n < RANDOM_COLOURS; n++) begin
            if (n == RANDOM_COLOURS / 2)
                drain_pipeline();
            pick_colour(l, a, b);
            offer_colour(l, a, b, !(n >= 300 && n < 450));
        end
        pix_in.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d colours: %0d corner cases, the rest random incl. raw bits.",
                 colours_sent, directed_count);
        $display("Output held off %0d times; input drained to empty %0d times.",
                 long_holds, drain_pauses);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/o2s_pkg.sv
rtl/o2s_in_if.sv
rtl/o2s_out_if.sv
rtl/o2s_lms.sv
rtl/o2s_cube.sv
rtl/o2s_rgb.sv
rtl/o2s_gamma.sv
rtl/oklab_to_srgb_converter.sv
sim/oklab_to_srgb_checker.sv
sim/oklab_to_srgb_converter_test.sv
